// ----- rtl/qpe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package qpe_pkg;

   // Sizes
   localparam int MAX_KEY_BYTES = 8;
   localparam int MAX_RESULTS   = 4;
   localparam int QUEUE_DEPTH   = 4;

   localparam int KEY_POS_W = $clog2(MAX_KEY_BYTES + 1);
   localparam int KEY_IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int CNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int RES_IDX_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
   localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int KEY_LEN_W  = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_KEY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH = 2'd1;

   // Result kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_MISSING = 2'd2;

   // Characters
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   typedef enum logic [1:0] {
      PH_KEY,
      PH_VALUE,
      PH_SKIP,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_PERCENT,
      ESC_DIGIT
   } escape_type;

   typedef struct packed {
      logic [7:0] query_byte;
      logic       no_byte;
      logic       query_end;
   } req_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic [1:0] kind;
      logic       run_end;
   } rsp_type;

   // All results caused by one accepted item
   typedef struct packed {
      logic [CNT_W-1:0]             count;
      rsp_type [MAX_RESULTS-1:0]    res;
   } bundle_type;

   // Hex digit decode: bit 4 flags a valid digit, bits 3..0 its value
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/qpe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Front end: holds the configuration and the parse state, and turns each
// accepted byte into a bundle of up to MAX_RESULTS results.
module qpe_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   input  wire logic                            queue_full,
   input  wire qpe_pkg::req_type                req_data,
   input  wire logic                            csr_we,
   input  wire logic [qpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [qpe_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                                 bundle_push,
   output qpe_pkg::bundle_type                  bundle
);

   logic [qpe_pkg::CSR_DATA_W-1:0] search_key_ff;
   logic [qpe_pkg::KEY_LEN_W-1:0]  key_length_ff;

   qpe_pkg::phase_type             phase_ff, phase_in;
   logic [qpe_pkg::KEY_POS_W-1:0]  key_pos_ff, key_pos_in;
   logic                           key_mis_ff, key_mis_in;
   qpe_pkg::escape_type            esc_ff, esc_in;
   logic [7:0]                     held_ff, held_in;
   qpe_pkg::bundle_type            bnd;
   logic                           accept;

   // Append one result to a bundle
   function automatic qpe_pkg::bundle_type put_res(input qpe_pkg::bundle_type b,
                                                   input logic [7:0] v,
                                                   input logic [1:0] k);
      qpe_pkg::bundle_type r;
      r = b;
      if (r.count < qpe_pkg::CNT_W'(qpe_pkg::MAX_RESULTS)) begin
         r.res[r.count[qpe_pkg::RES_IDX_W-1:0]].value_byte = v;
         r.res[r.count[qpe_pkg::RES_IDX_W-1:0]].kind       = k;
         r.res[r.count[qpe_pkg::RES_IDX_W-1:0]].run_end    = 1'b0;
         r.count = r.count + qpe_pkg::CNT_W'(1);
      end
      return r;
   endfunction

   // Key length in use, zero when out of range
   function automatic logic [qpe_pkg::KEY_POS_W-1:0] active_len(
         input logic [qpe_pkg::KEY_LEN_W-1:0] l);
      logic [qpe_pkg::KEY_POS_W-1:0] r;
      r = '0;
      if (l != '0 && l <= qpe_pkg::KEY_LEN_W'(qpe_pkg::MAX_KEY_BYTES)) begin
         r = qpe_pkg::KEY_POS_W'(l);
      end
      return r;
   endfunction

   assign accept = push && !queue_full;

   // Classify the byte and build its results
   always_comb begin
      logic [qpe_pkg::KEY_POS_W-1:0] len;
      logic                          matched;
      logic                          take;
      logic [4:0]                    lo_hex;
      logic [4:0]                    hi_hex;
      logic [7:0]                    b;
      logic [7:0]                    key_byte;

      phase_in   = phase_ff;
      key_pos_in = key_pos_ff;
      key_mis_in = key_mis_ff;
      esc_in     = esc_ff;
      held_in    = held_ff;
      bnd        = '0;
      take       = 1'b1;

      b        = req_data.query_byte;
      len      = active_len(key_length_ff);
      matched  = (len != '0) && !key_mis_ff && (key_pos_ff == len);
      lo_hex   = qpe_pkg::hex_nibble(b);
      hi_hex   = qpe_pkg::hex_nibble(held_ff);
      key_byte = search_key_ff[{key_pos_ff[qpe_pkg::KEY_IDX_W-1:0], 3'b000} +: 8];

      if (!req_data.no_byte) begin
         case (phase_ff)
            qpe_pkg::PH_KEY: begin
               if (b == qpe_pkg::CH_AMP) begin
                  if (matched) begin
                     bnd      = put_res(bnd, 8'h00, qpe_pkg::KIND_END);
                     phase_in = qpe_pkg::PH_DONE;
                  end else begin
                     key_pos_in = '0;
                     key_mis_in = 1'b0;
                  end
               end else if (b == qpe_pkg::CH_EQUALS) begin
                  phase_in = matched ? qpe_pkg::PH_VALUE : qpe_pkg::PH_SKIP;
               end else if (!key_mis_ff && key_pos_ff < len && key_byte == b) begin
                  key_pos_in = key_pos_ff + qpe_pkg::KEY_POS_W'(1);
               end else begin
                  key_mis_in = 1'b1;
               end
            end
            qpe_pkg::PH_VALUE: begin
               // settle a pending escape first
               if (esc_ff == qpe_pkg::ESC_PERCENT) begin
                  if (lo_hex[4]) begin
                     held_in = b;
                     esc_in  = qpe_pkg::ESC_DIGIT;
                     take    = 1'b0;
                  end else begin
                     bnd    = put_res(bnd, qpe_pkg::CH_PERCENT, qpe_pkg::KIND_BYTE);
                     esc_in = qpe_pkg::ESC_NONE;
                  end
               end else if (esc_ff == qpe_pkg::ESC_DIGIT) begin
                  if (lo_hex[4]) begin
                     bnd    = put_res(bnd, {hi_hex[3:0], lo_hex[3:0]}, qpe_pkg::KIND_BYTE);
                     esc_in = qpe_pkg::ESC_NONE;
                     take   = 1'b0;
                  end else begin
                     bnd    = put_res(bnd, qpe_pkg::CH_PERCENT, qpe_pkg::KIND_BYTE);
                     bnd    = put_res(bnd, held_ff, qpe_pkg::KIND_BYTE);
                     esc_in = qpe_pkg::ESC_NONE;
                  end
               end
               if (take) begin
                  if (b == qpe_pkg::CH_AMP) begin
                     bnd      = put_res(bnd, 8'h00, qpe_pkg::KIND_END);
                     phase_in = qpe_pkg::PH_DONE;
                  end else if (b == qpe_pkg::CH_PLUS) begin
                     bnd = put_res(bnd, qpe_pkg::CH_SPACE, qpe_pkg::KIND_BYTE);
                  end else if (b == qpe_pkg::CH_PERCENT) begin
                     esc_in = qpe_pkg::ESC_PERCENT;
                  end else begin
                     bnd = put_res(bnd, b, qpe_pkg::KIND_BYTE);
                  end
               end
            end
            qpe_pkg::PH_SKIP: begin
               if (b == qpe_pkg::CH_AMP) begin
                  phase_in   = qpe_pkg::PH_KEY;
                  key_pos_in = '0;
                  key_mis_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      // close the query and return to the start state
      if (req_data.query_end) begin
         matched = (len != '0) && !key_mis_in && (key_pos_in == len);
         case (phase_in)
            qpe_pkg::PH_KEY: begin
               bnd = put_res(bnd, 8'h00,
                             matched ? qpe_pkg::KIND_END : qpe_pkg::KIND_MISSING);
            end
            qpe_pkg::PH_VALUE: begin
               if (esc_in == qpe_pkg::ESC_PERCENT) begin
                  bnd = put_res(bnd, qpe_pkg::CH_PERCENT, qpe_pkg::KIND_BYTE);
               end else if (esc_in == qpe_pkg::ESC_DIGIT) begin
                  bnd = put_res(bnd, qpe_pkg::CH_PERCENT, qpe_pkg::KIND_BYTE);
                  bnd = put_res(bnd, held_in, qpe_pkg::KIND_BYTE);
               end
               bnd = put_res(bnd, 8'h00, qpe_pkg::KIND_END);
            end
            qpe_pkg::PH_SKIP: begin
               bnd = put_res(bnd, 8'h00, qpe_pkg::KIND_MISSING);
            end
            default: begin
            end
         endcase
         phase_in   = qpe_pkg::PH_KEY;
         key_pos_in = '0;
         key_mis_in = 1'b0;
         esc_in     = qpe_pkg::ESC_NONE;
         held_in    = 8'h00;
      end

      // flag the last result of this item
      if (bnd.count != '0) begin
         bnd.res[qpe_pkg::RES_IDX_W'(bnd.count - qpe_pkg::CNT_W'(1))].run_end = 1'b1;
      end
   end

   assign bundle      = bnd;
   assign bundle_push = accept && (bnd.count != '0);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         search_key_ff <= '0;
         key_length_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == qpe_pkg::CSR_SEARCH_KEY) begin
            search_key_ff <= csr_wdata;
         end else if (csr_index == qpe_pkg::CSR_KEY_LENGTH) begin
            key_length_ff <= csr_wdata[qpe_pkg::KEY_LEN_W-1:0];
         end
      end
   end

   // Parse state, advanced on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= qpe_pkg::PH_KEY;
         key_pos_ff <= '0;
         key_mis_ff <= 1'b0;
         esc_ff     <= qpe_pkg::ESC_NONE;
         held_ff    <= 8'h00;
      end else if (accept) begin
         phase_ff   <= phase_in;
         key_pos_ff <= key_pos_in;
         key_mis_ff <= key_mis_in;
         esc_ff     <= esc_in;
         held_ff    <= held_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/qpe_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Short queue of result bundles between front and back
module qpe_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire qpe_pkg::bundle_type  push_data,
   output logic                      full,
   input  wire logic                 pop,
   output qpe_pkg::bundle_type       head,
   output logic                      empty
);

   qpe_pkg::bundle_type            slot_ff [qpe_pkg::QUEUE_DEPTH];
   logic [qpe_pkg::QPTR_W-1:0]     wr_ptr_ff;
   logic [qpe_pkg::QPTR_W-1:0]     rd_ptr_ff;
   logic [qpe_pkg::QCNT_W-1:0]     count_ff;
   logic                           do_push;
   logic                           do_pop;

   function automatic logic [qpe_pkg::QPTR_W-1:0] next_ptr(
         input logic [qpe_pkg::QPTR_W-1:0] p);
      logic [qpe_pkg::QPTR_W-1:0] r;
      if (p == qpe_pkg::QPTR_W'(qpe_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + qpe_pkg::QPTR_W'(1);
      end
      return r;
   endfunction

   assign full    = (count_ff == qpe_pkg::QCNT_W'(qpe_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   // Store incoming bundle
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + qpe_pkg::QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - qpe_pkg::QCNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/qpe_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Back end: takes one bundle at a time and hands its results out in order
module qpe_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire qpe_pkg::bundle_type  head,
   input  wire logic                 queue_empty,
   output logic                      queue_pop,
   output logic                      empty,
   input  wire logic                 pop,
   output qpe_pkg::rsp_type          rsp_data
);

   qpe_pkg::bundle_type            cur_ff;
   logic [qpe_pkg::RES_IDX_W-1:0]  idx_ff;
   logic                           valid_ff;
   logic                           advance;
   logic                           last;
   logic                           reload;

   assign advance   = valid_ff && pop;
   assign last      = (qpe_pkg::CNT_W'(idx_ff) == cur_ff.count - qpe_pkg::CNT_W'(1));
   assign reload    = !valid_ff || (advance && last);
   assign queue_pop = reload && !queue_empty;

   assign empty    = !valid_ff;
   assign rsp_data = cur_ff.res[idx_ff];

   // Hold the current bundle
   always_ff @(posedge clock) begin
      if (queue_pop) begin
         cur_ff <= head;
      end
   end

   // Step through results, reload on the last transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (reload) begin
         valid_ff <= !queue_empty;
         idx_ff   <= '0;
      end else if (advance) begin
         idx_ff <= idx_ff + qpe_pkg::RES_IDX_W'(1);
      end
   end

endmodule

`default_nettype wire

// ----- rtl/query_parameter_extractor.sv -----
// Query parameter extractor.
// Input queue side: drive req_data with one query byte and raise push; the
// byte transfers at a clock edge where push is high and full is low. Set
// no_byte for an item that only closes an empty query, query_end on the
// last item of a query.
// Result queue side: while empty is low, rsp_data shows the oldest result
// (decoded value byte, end of value, or key not found); it transfers at an
// edge with pop high. run_end marks the last result of one input item.
// Configuration: csr_we writes csr_wdata to register csr_index (0 search
// key, 1 key length) in the same cycle; write only while the block is idle.
// A result passes through the queue slot and then the output register before
// it shows on rsp_data.
// Throughput: one item per cycle while full is low and each item gives at
// most one result; an item that gives several results holds the result side
// while the single output register steps through its bundle. A four-bundle
// queue between parser and output absorbs bursts; full rises when it fills.
// A stalled receiver first fills that queue, then full stalls the sender.
// Reset clears the parse state, both registers, the queue and the output.
`timescale 1ns / 1ps
`default_nettype none

module query_parameter_extractor (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   output logic                                 full,
   input  wire qpe_pkg::req_type                req_data,
   output logic                                 empty,
   input  wire logic                            pop,
   output qpe_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [qpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [qpe_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                 bundle_push;
   qpe_pkg::bundle_type  bundle;
   qpe_pkg::bundle_type  head;
   logic                 queue_empty;
   logic                 queue_pop;

   // Parse and classify
   qpe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .queue_full  (full),
      .req_data    (req_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .bundle_push (bundle_push),
      .bundle      (bundle)
   );

   // Decouple front from back
   qpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (bundle_push),
      .push_data (bundle),
      .full      (full),
      .pop       (queue_pop),
      .head      (head),
      .empty     (queue_empty)
   );

   // Serialise results
   qpe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/qpe_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qpe_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              push,
   input wire logic              full,
   input wire logic              empty,
   input wire logic              pop,
   input wire qpe_pkg::rsp_type  rsp_data
);

   logic in_xfer;
   assign in_xfer = push && !full;

   // Come out of reset with nothing held and room for input
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("block not cleared by reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("stalled result changed");

   // No result appears without a recent input transfer
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (empty && !in_xfer && !$past(in_xfer)) |=> empty)
      else $error("result appeared without input");

   // Markers carry a zero byte, and the kind is a known code
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.kind == qpe_pkg::KIND_BYTE ||
                  (rsp_data.value_byte == 8'h00 &&
                   (rsp_data.kind == qpe_pkg::KIND_END ||
                    rsp_data.kind == qpe_pkg::KIND_MISSING))))
      else $error("bad marker result");

endmodule

bind query_parameter_extractor qpe_checker u_checker (.*);

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import qpe_pkg::*;

   // Register indexes that the block ignores
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum logic {ROW_ITEM, ROW_REG} row_op_type;

   // One line of the directed script: a register write or a query byte
   typedef struct {
      row_op_type            op;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      req_type               item;
      bit                    typed;
      rsp_type               want;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  pop = 1'b0;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   req_type               req_data = '0;
   logic                  full;
   logic                  empty;
   rsp_type               rsp_data;

   // Parser state and register copies of the decoder model
   phase_type   pr_phase = PH_KEY;
   logic [3:0]  pr_pos = 4'd0;
   logic        pr_miss = 1'b0;
   escape_type  pr_esc = ESC_NONE;
   logic [7:0]  pr_held = 8'h00;
   logic [63:0] cfg_key = 64'h0;
   logic [3:0]  cfg_len = 4'd0;

   rsp_type item_results [$];
   rsp_type due_results [$];
   req_type query_q [$];
   rsp_type head;

   int mismatch_count = 0;
   int sent_count = 0;
   int send_gap_pct = 26;
   int take_gap_pct = 53;

   query_parameter_extractor uut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0h, want %0h at %0t ns", what, got, want, $time);
      mismatch_count++;
   endtask

   // Decode helpers of the model
   function automatic int hex_val(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic logic [3:0] key_span();
      return (cfg_len >= 4'd1 && cfg_len <= 4'(MAX_KEY_BYTES)) ? cfg_len : 4'd0;
   endfunction

   function automatic bit key_hit();
      return key_span() != 4'd0 && !pr_miss && pr_pos == key_span();
   endfunction

   function automatic void emit(input logic [7:0] v, input logic [1:0] k);
      rsp_type r;
      r.value_byte = v;
      r.kind = k;
      r.run_end = 1'b0;
      if (item_results.size() < MAX_RESULTS) item_results.push_back(r);
   endfunction

   function automatic void start_pair();
      pr_phase = PH_KEY;
      pr_pos = 4'd0;
      pr_miss = 1'b0;
   endfunction

   // Flush any pending escape, then mark the end of the found value
   function automatic void close_value();
      if (pr_esc == ESC_PERCENT) begin
         emit(CH_PERCENT, KIND_BYTE);
      end else if (pr_esc == ESC_DIGIT) begin
         emit(CH_PERCENT, KIND_BYTE);
         emit(pr_held, KIND_BYTE);
      end
      pr_esc = ESC_NONE;
      emit(8'h00, KIND_END);
      pr_phase = PH_DONE;
   endfunction

   // Work out the results of one accepted item into item_results
   function automatic void parse_item(input req_type it);
      logic [7:0] b;
      bit         redo;
      int         hi;
      int         lo;
      rsp_type    tail;
      item_results.delete();
      b = it.query_byte;
      if (!it.no_byte) begin
         case (pr_phase)
            PH_KEY: begin
               if (b == CH_AMP) begin
                  if (key_hit()) begin
                     emit(8'h00, KIND_END);
                     pr_phase = PH_DONE;
                  end else begin
                     start_pair();
                  end
               end else if (b == CH_EQUALS) begin
                  pr_phase = key_hit() ? PH_VALUE : PH_SKIP;
               end else if (!pr_miss && pr_pos < key_span() &&
                            8'(cfg_key >> (8 * pr_pos)) == b) begin
                  pr_pos = pr_pos + 4'd1;
               end else begin
                  pr_miss = 1'b1;
               end
            end
            PH_VALUE: begin
               redo = 1'b1;
               lo = hex_val(b);
               if (pr_esc == ESC_PERCENT) begin
                  if (lo >= 0) begin
                     pr_held = b;
                     pr_esc = ESC_DIGIT;
                     redo = 1'b0;
                  end else begin
                     emit(CH_PERCENT, KIND_BYTE);
                     pr_esc = ESC_NONE;
                  end
               end else if (pr_esc == ESC_DIGIT) begin
                  if (lo >= 0) begin
                     hi = hex_val(pr_held);
                     emit(8'(hi * 16 + lo), KIND_BYTE);
                     pr_esc = ESC_NONE;
                     redo = 1'b0;
                  end else begin
                     emit(CH_PERCENT, KIND_BYTE);
                     emit(pr_held, KIND_BYTE);
                     pr_esc = ESC_NONE;
                  end
               end
               // A bad escape hands the byte back to ordinary decoding
               if (redo) begin
                  if (b == CH_AMP) close_value();
                  else if (b == CH_PLUS) emit(CH_SPACE, KIND_BYTE);
                  else if (b == CH_PERCENT) pr_esc = ESC_PERCENT;
                  else emit(b, KIND_BYTE);
               end
            end
            PH_SKIP: begin
               if (b == CH_AMP) start_pair();
            end
            default: begin
            end
         endcase
      end
      if (it.query_end) begin
         case (pr_phase)
            PH_KEY:   emit(8'h00, key_hit() ? KIND_END : KIND_MISSING);
            PH_VALUE: close_value();
            PH_SKIP:  emit(8'h00, KIND_MISSING);
            default: begin
            end
         endcase
         start_pair();
         pr_esc = ESC_NONE;
         pr_held = 8'h00;
      end
      if (item_results.size() > 0) begin
         tail = item_results.pop_back();
         tail.run_end = 1'b1;
         item_results.push_back(tail);
      end
   endfunction

   function automatic req_type query_item(input logic [7:0] b, input logic nb,
                                          input logic qe);
      req_type r;
      r.query_byte = b;
      r.no_byte = nb;
      r.query_end = qe;
      return r;
   endfunction

   function automatic script_row_type item_row(input logic [7:0] b, input logic nb,
                                               input logic qe);
      script_row_type r;
      r.op = ROW_ITEM;
      r.idx = '0;
      r.data = '0;
      r.item = query_item(b, nb, qe);
      r.typed = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic script_row_type fixed_row(input logic [7:0] b, input logic nb,
                                                input logic qe, input logic [7:0] vb,
                                                input logic [1:0] k);
      script_row_type r;
      r = item_row(b, nb, qe);
      r.typed = 1'b1;
      r.want.value_byte = vb;
      r.want.kind = k;
      r.want.run_end = 1'b1;
      return r;
   endfunction

   function automatic script_row_type reg_row(input logic [CSR_IDX_W-1:0] idx,
                                              input logic [CSR_DATA_W-1:0] val);
      script_row_type r;
      r = item_row(8'h00, 1'b0, 1'b0);
      r.op = ROW_REG;
      r.idx = idx;
      r.data = val;
      return r;
   endfunction

   function automatic logic [7:0] key_char();
      case ($urandom_range(5))
         0: return "a";
         1: return "b";
         2: return "c";
         3: return "1";
         4: return CH_PERCENT;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] value_char();
      case ($urandom_range(13))
         0: return "a";
         1: return "Z";
         2: return "0";
         3: return "9";
         4: return "f";
         5: return "F";
         6: return "g";
         7, 8: return CH_PERCENT;
         9: return CH_PLUS;
         10: return CH_EQUALS;
         11: return CH_AMP;
         12: return ":";
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Offer one item, hold it until it transfers, then log what it should give
   task automatic send_item(input req_type it, input bit typed, input rsp_type fixed);
      while ($urandom_range(99) < send_gap_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (full) @(posedge clock);
      parse_item(it);
      if (typed) begin
         due_results.push_back(fixed);
      end else begin
         foreach (item_results[k]) due_results.push_back(item_results[k]);
      end
      sent_count++;
      if (sent_count == 50) begin
         send_gap_pct = 53;
         take_gap_pct = 26;
      end else if (sent_count == 100) begin
         send_gap_pct = 0;
         take_gap_pct = 0;
      end
      @(negedge clock);
   endtask

   // Drop push and wait until every due result has come, plus a margin
   task automatic settle(input int extra);
      push <= 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      settle(6);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SEARCH_KEY) cfg_key = val;
      else if (idx == CSR_KEY_LENGTH) cfg_len = val[3:0];
   endtask

   // Build one query: pairs with the search key, near misses and noise
   task automatic compose_query();
      int      pairs;
      int      n;
      int      pick;
      int      span;
      req_type last;
      query_q.delete();
      pairs = $urandom_range(3, 1);
      span = (key_span() != 4'd0) ? int'(key_span()) : $urandom_range(8, 1);
      for (int p = 0; p < pairs; p++) begin
         if (p > 0) query_q.push_back(query_item(CH_AMP, 1'b0, 1'b0));
         pick = $urandom_range(99);
         if (pick < 50) n = span;
         else if (pick < 65) n = span - 1;
         else if (pick < 80) n = span + 1;
         else n = $urandom_range(3);
         for (int i = 0; i < n; i++) begin
            query_q.push_back(query_item((pick < 80 && i < span) ?
                                         8'(cfg_key >> (8 * i)) : key_char(),
                                         1'b0, 1'b0));
         end
         if ($urandom_range(99) < 85) begin
            query_q.push_back(query_item(CH_EQUALS, 1'b0, 1'b0));
            n = $urandom_range(5);
            for (int i = 0; i < n; i++) query_q.push_back(query_item(value_char(), 1'b0, 1'b0));
         end
      end
      foreach (query_q[i]) begin
         if ($urandom_range(99) < 5) begin
            last = query_q[i];
            last.query_byte = 8'($urandom_range(255));
            query_q[i] = last;
         end
      end
      // Close either on the last byte or with a byteless end item
      if (query_q.size() == 0 || $urandom_range(99) < 30) begin
         query_q.push_back(query_item(8'($urandom_range(255)), 1'b1, 1'b1));
      end else begin
         last = query_q.pop_back();
         last.query_end = 1'b1;
         query_q.push_back(last);
      end
   endtask

   // Receiver: pop with random stalls
   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= take_gap_pct);
   end

   // Compare each transfer with the oldest due result
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (due_results.size() == 0) begin
            flag_mismatch("result with none due", int'(rsp_data), 0);
         end else begin
            head = due_results.pop_front();
            if (rsp_data.value_byte !== head.value_byte)
               flag_mismatch("value_byte", int'(rsp_data.value_byte), int'(head.value_byte));
            if (rsp_data.kind !== head.kind)
               flag_mismatch("kind", int'(rsp_data.kind), int'(head.kind));
            if (rsp_data.run_end !== head.run_end)
               flag_mismatch("run_end", int'(rsp_data.run_end), int'(head.run_end));
         end
      end
   end

   initial begin
      script_row_type            plan [$];
      logic [CSR_DATA_W-1:0]     key;
      logic [3:0]                len;
      int                        phase_items;
      plan = '{
         fixed_row(8'h00, 1'b1, 1'b1, 8'h00, KIND_MISSING),
         reg_row(CSR_SEARCH_KEY, 64'h6261),
         reg_row(CSR_KEY_LENGTH, 64'd2),
         reg_row(CSR_SPARE_3, '1),
         reg_row(CSR_SPARE_2, 64'h0),
         item_row("a", 1'b0, 1'b0),
         item_row("b", 1'b0, 1'b0),
         item_row(CH_EQUALS, 1'b0, 1'b0),
         item_row(CH_PERCENT, 1'b0, 1'b0),
         item_row("4", 1'b0, 1'b0),
         item_row("1", 1'b0, 1'b0),
         item_row(CH_PLUS, 1'b0, 1'b0),
         item_row(CH_PERCENT, 1'b0, 1'b0),
         item_row("z", 1'b0, 1'b0),
         item_row(CH_PERCENT, 1'b0, 1'b0),
         item_row("f", 1'b0, 1'b0),
         fixed_row("F", 1'b0, 1'b0, 8'hFF, KIND_BYTE),
         fixed_row(CH_AMP, 1'b0, 1'b0, 8'h00, KIND_END),
         item_row("x", 1'b0, 1'b1),
         item_row(8'hA5, 1'b1, 1'b0),
         item_row("a", 1'b0, 1'b0),
         fixed_row("b", 1'b0, 1'b1, 8'h00, KIND_END),
         item_row("a", 1'b0, 1'b0),
         item_row("b", 1'b0, 1'b0),
         item_row(CH_EQUALS, 1'b0, 1'b0),
         item_row(CH_PERCENT, 1'b0, 1'b0),
         item_row("9", 1'b0, 1'b1),
         reg_row(CSR_SEARCH_KEY, '1),
         reg_row(CSR_KEY_LENGTH, 64'd15),
         fixed_row(8'hFF, 1'b0, 1'b1, 8'h00, KIND_MISSING)
      };

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed script
      foreach (plan[i]) begin
         if (plan[i].op == ROW_REG) write_reg(plan[i].idx, plan[i].data);
         else send_item(plan[i].item, plan[i].typed, plan[i].want);
      end

      // Random queries under a series of key settings
      for (int p = 0; p < 6; p++) begin
         for (int i = 0; i < 8; i++) key[8 * i +: 8] = key_char();
         case (p)
            0: len = 4'd1;
            1: begin
               key = '1;
               len = 4'd8;
            end
            2: begin
               key = '0;
               len = 4'd0;
            end
            3: len = 4'd15;
            4: len = 4'd3;
            default: len = 4'($urandom_range(8, 1));
         endcase
         write_reg(CSR_SEARCH_KEY, key);
         write_reg(CSR_KEY_LENGTH, CSR_DATA_W'(len));
         phase_items = 0;
         while (phase_items < 12) begin
            compose_query();
            foreach (query_q[i]) begin
               if ($urandom_range(99) < 4)
                  send_item(query_item(8'($urandom_range(255)), 1'b1, 1'b0), 1'b0, '0);
               send_item(query_q[i], 1'b0, '0);
               phase_items++;
            end
         end
      end

      settle(20);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- query_parameter_extractor.f -----
rtl/qpe_pkg.sv
rtl/qpe_front.sv
rtl/qpe_queue.sv
rtl/qpe_back.sv
rtl/query_parameter_extractor.sv
rtl/qpe_checker.sv
verif/tb_top.sv
